// File: hw/rtl/czgr_pkg.sv
// Shared types and constants for the zone greedy routing block.
// Depends on nothing; every other file imports it.
package czgr_pkg;

    // Field widths fixed by the item format.
    localparam int COORD_BITS          = 10;
    localparam int LEN_BITS            = COORD_BITS + 1;
    localparam int RANK_BITS           = 8;
    localparam int DIST_BITS           = 2 * LEN_BITS + 1;
    localparam int CMD_BITS            = 2;
    localparam int STATUS_BITS         = 3;
    localparam int DEFAULT_TABLE_DEPTH = 16;

    // Configuration port geometry.
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [LEN_BITS-1:0] ZONE_EXTENT_RESET = LEN_BITS'(1000);

    // Request commands.
    typedef enum logic [CMD_BITS-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ROUTE  = 2'd2
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE    = 3'd0,
        ST_LOCAL   = 3'd1,
        ST_FORWARD = 3'd2,
        ST_NONE    = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_ZONE_X      = 2'd0,
        REG_ZONE_Y      = 2'd1,
        REG_ZONE_WIDTH  = 2'd2,
        REG_ZONE_HEIGHT = 2'd3
    } reg_idx_t;

    // One neighbor table entry.
    typedef struct packed {
        logic [COORD_BITS-1:0] border_x;
        logic [COORD_BITS-1:0] border_y;
        logic [LEN_BITS-1:0]   border_length;
        logic                  horizontal;
        logic [RANK_BITS-1:0]  rank;
    } entry_t;

    // Output of the distance unit, one per scanned entry.
    typedef struct packed {
        logic                 valid;
        logic [DIST_BITS-1:0] sq_dist;
        logic [RANK_BITS-1:0] rank;
    } dist_res_t;

endpackage

// File: hw/rtl/czgr_table.sv
// Neighbor table memory: one write port and one registered read port.
// Depends on czgr_pkg for the entry layout.
module czgr_table import czgr_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_idx,
    input  entry_t                         wr_entry,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_idx,
    output entry_t                         rd_entry,
    output logic                           rd_valid
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_entry_reg;
    logic   rd_valid_reg;

    // Storage and registered read data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_entry;
        end
        if (rd_en) begin
            rd_entry_reg <= mem[rd_idx];
        end
    end

    // Read data qualifier.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// File: hw/rtl/czgr_dist.sv
// Shared distance unit: squared distance from a query point to a border midpoint.
// Two register stages (squares, then sum). Depends on czgr_pkg.
module czgr_dist import czgr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  entry_t                entry,
    input  logic [COORD_BITS-1:0] query_x,
    input  logic [COORD_BITS-1:0] query_y,
    output dist_res_t             res
);

    logic [LEN_BITS-1:0]   half;
    logic [LEN_BITS-1:0]   mid_x;
    logic [LEN_BITS-1:0]   mid_y;
    logic [LEN_BITS-1:0]   qx_ext;
    logic [LEN_BITS-1:0]   qy_ext;
    logic [LEN_BITS-1:0]   diff_x;
    logic [LEN_BITS-1:0]   diff_y;
    logic [2*LEN_BITS-1:0] sq_x_reg;
    logic [2*LEN_BITS-1:0] sq_y_reg;
    logic [RANK_BITS-1:0]  sq_rank_reg;
    logic                  sq_valid_reg;
    logic [DIST_BITS-1:0]  res_dist_reg;
    logic [RANK_BITS-1:0]  res_rank_reg;
    logic                  res_valid_reg;

    // Border midpoint and absolute coordinate differences.
    always_comb begin
        half   = {1'b0, entry.border_length[LEN_BITS-1:1]};
        qx_ext = {1'b0, query_x};
        qy_ext = {1'b0, query_y};
        mid_x  = {1'b0, entry.border_x} + (entry.horizontal ? half : '0);
        mid_y  = {1'b0, entry.border_y} + (entry.horizontal ? '0 : half);
        diff_x = (mid_x >= qx_ext) ? (mid_x - qx_ext) : (qx_ext - mid_x);
        diff_y = (mid_y >= qy_ext) ? (mid_y - qy_ext) : (qy_ext - mid_y);
    end

    // Stage one: squares. Stage two: their sum.
    always_ff @(posedge aclk) begin
        sq_x_reg     <= diff_x * diff_x;
        sq_y_reg     <= diff_y * diff_y;
        sq_rank_reg  <= entry.rank;
        res_dist_reg <= {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
        res_rank_reg <= sq_rank_reg;
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            sq_valid_reg  <= in_valid;
            res_valid_reg <= sq_valid_reg;
        end
    end

    assign res = '{valid: res_valid_reg, sq_dist: res_dist_reg, rank: res_rank_reg};

endmodule

// File: hw/rtl/can_zone_greedy_route.sv
// Channel   Direction  Handshake               Payload
// s_        in         s_tvalid / s_tready     tuser = cmd, tdata = neighbor and query fields
// m_        out        m_tvalid / m_tready     tuser = status, tdata = next_rank
// apb       in         psel / penable / pready zone registers at byte address 4*i
//
// Clear, insert and unused commands, and routes settled by the zone test or an
// empty table, pass through the execute and response states to the result.
// A route outside the zone adds the scan and drain states: the table has one read
// port, so the scan reads one entry per cycle into the two-stage distance unit.
// A result waits in the output register; the next request is taken meanwhile,
// but a new result is not loaded until the previous one has been taken.
// Reset is synchronous on aresetn and empties the neighbor table.
// Top level: sequencer, zone registers and output register. Depends on czgr_pkg,
// czgr_table and czgr_dist.
module can_zone_greedy_route import czgr_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Request channel.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [9:0] in_border_x, [19:10] in_border_y, [30:20] in_border_length,
    // [31] in_border_horizontal, [39:32] in_rank, [49:40] query_x,
    // [59:50] query_y, [63:60] zero
    input  logic [63:0]              s_tdata,
    // [1:0] cmd
    input  logic [CMD_BITS-1:0]      s_tuser,
    // Result channel.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [7:0] next_rank
    output logic [RANK_BITS-1:0]     m_tdata,
    // [2:0] status
    output logic [STATUS_BITS-1:0]   m_tuser,
    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [CMD_BITS-1:0]   cmd_reg;
    entry_t                in_entry_reg;
    logic [COORD_BITS-1:0] query_x_reg;
    logic [COORD_BITS-1:0] query_y_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic [1:0]            drain_reg, drain_next;
    status_t               res_status_reg, res_status_next;
    logic [DIST_BITS-1:0]  best_dist_reg;
    logic [RANK_BITS-1:0]  best_rank_reg;
    logic                  best_valid_reg, best_valid_next;
    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_BITS-1:0] m_status_reg;
    logic [RANK_BITS-1:0]  m_rank_reg;
    logic [COORD_BITS-1:0] zone_x_reg;
    logic [COORD_BITS-1:0] zone_y_reg;
    logic [LEN_BITS-1:0]   zone_width_reg;
    logic [LEN_BITS-1:0]   zone_height_reg;

    logic                  in_accept;
    logic                  cfg_write;
    logic                  out_free;
    logic                  in_zone;
    logic [LEN_BITS:0]     zone_x_end;
    logic [LEN_BITS:0]     zone_y_end;
    logic                  wr_en;
    logic                  rd_en;
    entry_t                rd_entry;
    logic                  rd_valid;
    dist_res_t             dres;
    logic                  best_take;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    // Zone test on the half-open rectangle, sums formed without wrap.
    always_comb begin
        zone_x_end = {2'b00, zone_x_reg} + {1'b0, zone_width_reg};
        zone_y_end = {2'b00, zone_y_reg} + {1'b0, zone_height_reg};
        in_zone    = (query_x_reg >= zone_x_reg)
                  && ({2'b00, query_x_reg} < zone_x_end)
                  && (query_y_reg >= zone_y_reg)
                  && ({2'b00, query_y_reg} < zone_y_end);
    end

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        drain_next      = drain_reg;
        res_status_next = res_status_reg;
        best_valid_next = best_valid_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_status_next = ST_DONE;
                state_next      = S_RESP;
                case (cmd_reg)
                    CMD_CLEAR: begin
                        count_next = '0;
                    end
                    CMD_INSERT: begin
                        if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                            res_status_next = ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = CNT_W'(count_reg + 1'b1);
                        end
                    end
                    CMD_ROUTE: begin
                        if (in_zone) begin
                            res_status_next = ST_LOCAL;
                        end else if (count_reg == '0) begin
                            res_status_next = ST_NONE;
                        end else begin
                            scan_next       = '0;
                            best_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                rd_en     = 1'b1;
                scan_next = CNT_W'(scan_reg + 1'b1);
                if (CNT_W'(scan_reg + 1'b1) == count_reg) begin
                    drain_next = 2'd2;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // Wait for the last entry to pass the read register and both
                // distance stages and update the best candidate.
                if (drain_reg == 2'd0) begin
                    res_status_next = ST_FORWARD;
                    state_next      = S_RESP;
                end else begin
                    drain_next = 2'(drain_reg - 1'b1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (best_take) begin
            best_valid_next = 1'b1;
        end
    end

    // Later entries win ties, so equal distances replace the best.
    assign best_take = dres.valid && (!best_valid_reg || (dres.sq_dist <= best_dist_reg));

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if ((state_reg == S_RESP) && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            scan_reg       <= '0;
            drain_reg      <= '0;
            best_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            res_status_reg <= ST_DONE;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            drain_reg      <= drain_next;
            best_valid_reg <= best_valid_next;
            m_valid_reg    <= m_valid_next;
            res_status_reg <= res_status_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cmd_reg                    <= s_tuser;
            in_entry_reg.border_x      <= s_tdata[9:0];
            in_entry_reg.border_y      <= s_tdata[19:10];
            in_entry_reg.border_length <= s_tdata[30:20];
            in_entry_reg.horizontal    <= s_tdata[31];
            in_entry_reg.rank          <= s_tdata[39:32];
            query_x_reg                <= s_tdata[49:40];
            query_y_reg                <= s_tdata[59:50];
        end
        if (best_take) begin
            best_dist_reg <= dres.sq_dist;
            best_rank_reg <= dres.rank;
        end
        if ((state_reg == S_RESP) && out_free) begin
            m_status_reg <= res_status_reg;
            m_rank_reg   <= (res_status_reg == ST_FORWARD) ? best_rank_reg : '0;
        end
    end

    // Zone registers, written from the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_x_reg      <= '0;
            zone_y_reg      <= '0;
            zone_width_reg  <= ZONE_EXTENT_RESET;
            zone_height_reg <= ZONE_EXTENT_RESET;
        end else if (cfg_write) begin
            case (reg_idx_t'(paddr[3:2]))
                REG_ZONE_X:      zone_x_reg      <= pwdata[COORD_BITS-1:0];
                REG_ZONE_Y:      zone_y_reg      <= pwdata[COORD_BITS-1:0];
                REG_ZONE_WIDTH:  zone_width_reg  <= pwdata[LEN_BITS-1:0];
                REG_ZONE_HEIGHT: zone_height_reg <= pwdata[LEN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx_t'(paddr[3:2]))
            REG_ZONE_X:      prdata = CFG_DATA_BITS'(zone_x_reg);
            REG_ZONE_Y:      prdata = CFG_DATA_BITS'(zone_y_reg);
            REG_ZONE_WIDTH:  prdata = CFG_DATA_BITS'(zone_width_reg);
            REG_ZONE_HEIGHT: prdata = CFG_DATA_BITS'(zone_height_reg);
            default:         prdata = '0;
        endcase
    end

    czgr_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_idx   (count_reg[IDX_W-1:0]),
        .wr_entry (in_entry_reg),
        .rd_en    (rd_en),
        .rd_idx   (scan_reg[IDX_W-1:0]),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid)
    );

    czgr_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_valid),
        .entry    (rd_entry),
        .query_x  (query_x_reg),
        .query_y  (query_y_reg),
        .res      (dres)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_rank_reg;

endmodule

// File: hw/rtl/czgr_checker.sv
// Port-level checks for the zone greedy routing block, bound to the top level.
// Depends on czgr_pkg for status codes.
module czgr_checker import czgr_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic [63:0]              s_tdata,
    input logic [CMD_BITS-1:0]      s_tuser,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [RANK_BITS-1:0]     m_tdata,
    input logic [STATUS_BITS-1:0]   m_tuser,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic [CFG_ADDR_BITS-1:0] paddr,
    input logic [CFG_DATA_BITS-1:0] pwdata,
    input logic [CFG_DATA_BITS-1:0] prdata,
    input logic                     pready
);

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only defined status codes are shown.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= STATUS_BITS'(ST_FULL)))
        else $error("undefined status code");

    // A rank is reported only with a forward status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_BITS'(ST_FORWARD)) |-> (m_tdata == '0))
        else $error("rank reported without forward");

    // One request at a time: ready drops after an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // The configuration port never waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable |-> pready)
        else $error("configuration access stalled");

endmodule

bind can_zone_greedy_route czgr_checker u_czgr_checker (.*);
